// ===== design/spc_pkg.sv =====
// Shared constants and types for the segment/plane classifier.
`default_nettype none
package spc_pkg;

  typedef logic [2:0] side_code_t;

  localparam side_code_t SIDE_IN_PLANE  = 3'd0;
  localparam side_code_t SIDE_CROSS_POS = 3'd1;
  localparam side_code_t SIDE_CROSS_NEG = 3'd2;
  localparam side_code_t SIDE_POS       = 3'd3;
  localparam side_code_t SIDE_NEG       = 3'd4;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_NORMAL_X     = 3'd0;
  localparam cfg_idx_t CFG_NORMAL_Y     = 3'd1;
  localparam cfg_idx_t CFG_NORMAL_Z     = 3'd2;
  localparam cfg_idx_t CFG_PLANE_OFFSET = 3'd3;
  localparam cfg_idx_t CFG_PAR_TOL      = 3'd4;

  // Operand slice width used when a long product is split into partial products.
  localparam int CHUNK_W = 32;

endpackage
`default_nettype wire

// ===== design/spc_ifs.sv =====
// Channel interfaces: segment input, classification result and register writes.
`default_nettype none
interface spc_seg_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface spc_res_if import spc_pkg::*; #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  side_code_t                    side_code;
  logic                          point_valid;
  logic signed [COORD_WIDTH-1:0] cross_x;
  logic signed [COORD_WIDTH-1:0] cross_y;
  logic signed [COORD_WIDTH-1:0] cross_z;
  modport source (output valid, side_code, point_valid, cross_x, cross_y, cross_z,
                  input ready);
  modport sink (input valid, side_code, point_valid, cross_x, cross_y, cross_z,
                output ready);
endinterface

interface spc_cfg_if import spc_pkg::*; #(parameter int COORD_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  cfg_idx_t               index;
  logic [COORD_WIDTH-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/segment_plane_classify.sv =====
// Top level: pipelined classifier of 3D segments against a configured plane.
`default_nettype none
// Classifies one segment per clock, while the result side does not stall, against
// the plane n.p + offset = 0 and returns the crossing code and the intersection
// point. The pipeline is COORD_WIDTH + 8 stages deep and takes a new segment in
// every cycle unless stalled; the depth is set by the restoring divider, which
// settles one quotient bit per stage for each of the three coordinates. Results
// leave in input order, and a stall on the result side holds the pipeline while
// any empty stages still fill. Register writes are accepted at any time but must
// only be issued while the pipeline is empty.
module segment_plane_classify import spc_pkg::*; #(
  parameter int COORD_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  spc_seg_if.sink     seg_i,
  spc_res_if.source   res_o,
  spc_cfg_if.sink     cfg_i
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int PW   = 2 * CW;
  localparam int DPW  = 2 * CW + 1;
  localparam int OW   = CW + FB;
  localparam int UW   = ((PW > OW) ? PW : OW) + 2;
  localparam int DW   = DPW + 2;
  localparam int EW   = ((UW > DW) ? UW : DW) + 1;
  localparam int AW   = CW + 1;
  localparam int NCH  = (UW + CHUNK_W - 1) / CHUNK_W;
  localparam int PPW  = AW + CHUNK_W;
  localparam int NMW  = AW + NCH * CHUNK_W;
  localparam int N2W  = NMW + 2;
  localparam int D2W  = DW + 1;
  localparam int QW   = CW + 2;
  localparam int TW   = CW - 1 + FB;
  localparam int CMPW = ((DW > TW) ? DW : TW) + 1;
  localparam int RW   = ((N2W > D2W + QW) ? N2W : D2W + QW) + 1;
  localparam int PTW  = QW + 3;
  localparam int NS   = QW + 6;

  localparam logic signed [PTW-1:0] CMAX = PTW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [PTW-1:0] CMIN = -CMAX - PTW'(1);

  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][CW-1:0] e;
    logic               u_pos;
    logic               u_neg;
    logic               e_pos;
    logic               e_zero;
    logic               par;
    logic [2:0]         qneg;
  } info_t;

  // Plane registers.
  logic signed [CW-1:0] nrm_q [3];
  logic signed [CW-1:0] off_q;
  logic [CW-2:0]        tol_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= CW'(1) << FB;
      off_q    <= '0;
      tol_q    <= (CW-1)'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_NORMAL_X:     nrm_q[0] <= cfg_i.data;
        CFG_NORMAL_Y:     nrm_q[1] <= cfg_i.data;
        CFG_NORMAL_Z:     nrm_q[2] <= cfg_i.data;
        CFG_PLANE_OFFSET: off_q    <= cfg_i.data;
        CFG_PAR_TOL:      tol_q    <= cfg_i.data[CW-2:0];
        default: ;
      endcase
    end
  end

  // Stage flow control: a stage moves when it is empty or its successor moves.
  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || res_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign seg_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= seg_i.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Stage 1: direction and the six normal products.
  logic signed [CW-1:0]  in_s [3];
  logic signed [CW-1:0]  in_e [3];
  logic signed [CW-1:0]  s1_s_q [3];
  logic signed [CW-1:0]  s1_e_q [3];
  logic signed [AW-1:0]  s1_dir_q [3];
  logic signed [PW-1:0]  s1_pu_q [3];
  logic signed [DPW-1:0] s1_pd_q [3];

  assign in_s[0] = seg_i.start_x;
  assign in_s[1] = seg_i.start_y;
  assign in_s[2] = seg_i.start_z;
  assign in_e[0] = seg_i.end_x;
  assign in_e[1] = seg_i.end_y;
  assign in_e[2] = seg_i.end_z;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int l = 0; l < 3; l++) begin
        s1_s_q[l]   <= in_s[l];
        s1_e_q[l]   <= in_e[l];
        s1_dir_q[l] <= AW'(in_e[l]) - AW'(in_s[l]);
        s1_pu_q[l]  <= PW'(in_s[l]) * PW'(nrm_q[l]);
        s1_pd_q[l]  <= DPW'(AW'(in_e[l]) - AW'(in_s[l])) * DPW'(nrm_q[l]);
      end
    end
  end

  // Stage 2: start distance U and direction dot product D.
  logic signed [CW-1:0] s2_s_q [3];
  logic signed [CW-1:0] s2_e_q [3];
  logic signed [AW-1:0] s2_dir_q [3];
  logic signed [UW-1:0] s2_u_q;
  logic signed [DW-1:0] s2_d_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_s_q   <= s1_s_q;
      s2_e_q   <= s1_e_q;
      s2_dir_q <= s1_dir_q;
      s2_u_q   <= UW'(s1_pu_q[0]) + UW'(s1_pu_q[1]) + UW'(s1_pu_q[2])
                + (UW'(off_q) <<< FB);
      s2_d_q   <= DW'(s1_pd_q[0]) + DW'(s1_pd_q[1]) + DW'(s1_pd_q[2]);
    end
  end

  // Stage 3: signs, parallel test and partial products of |dir| * |U|.
  logic signed [EW-1:0]       en_w;
  logic [UW-1:0]              abs_u;
  logic [DW-1:0]              abs_d;
  logic [NCH*CHUNK_W-1:0]     u_pad;
  logic [AW-1:0]              abs_dir [3];
  logic                       d_neg;
  info_t                      s3_info_q;
  logic [DW-1:0]              s3_absd_q;
  logic [PPW-1:0]             s3_pp_q [3][NCH];

  assign en_w   = EW'(s2_u_q) + EW'(s2_d_q);
  assign d_neg  = s2_d_q < 0;
  assign abs_u  = (s2_u_q < 0) ? UW'(-s2_u_q) : UW'(s2_u_q);
  assign abs_d  = d_neg ? DW'(-s2_d_q) : DW'(s2_d_q);
  assign u_pad  = (NCH*CHUNK_W)'(abs_u);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      abs_dir[l] = (s2_dir_q[l] < 0) ? AW'(-s2_dir_q[l]) : AW'(s2_dir_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int l = 0; l < 3; l++) begin
        s3_info_q.s[l]    <= s2_s_q[l];
        s3_info_q.e[l]    <= s2_e_q[l];
        // The quotient sign is sign(dir) * sign(-U) * sign(D).
        s3_info_q.qneg[l] <= (s2_dir_q[l] < 0) ^ (s2_u_q > 0) ^ d_neg;
        for (int c = 0; c < NCH; c++) begin
          s3_pp_q[l][c] <= PPW'(abs_dir[l]) * PPW'(u_pad[c*CHUNK_W +: CHUNK_W]);
        end
      end
      s3_info_q.u_pos  <= s2_u_q > 0;
      s3_info_q.u_neg  <= s2_u_q < 0;
      s3_info_q.e_pos  <= en_w > 0;
      s3_info_q.e_zero <= en_w == 0;
      s3_info_q.par    <= (s2_d_q == 0) ||
                          (CMPW'(abs_d) < (CMPW'(tol_q) << FB));
      s3_absd_q        <= abs_d;
    end
  end

  // Stage 4: rounded-division operands 2|num| + |D| and 2|D|.
  logic [NMW-1:0] num_w [3];
  info_t          s4_info_q;
  logic [N2W-1:0] s4_n2_q [3];
  logic [D2W-1:0] s4_d2_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num_w[l] = '0;
      for (int c = 0; c < NCH; c++) begin
        num_w[l] = num_w[l] + (NMW'(s3_pp_q[l][c]) << (c * CHUNK_W));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_info_q <= s3_info_q;
      for (int l = 0; l < 3; l++) begin
        s4_n2_q[l] <= (N2W'(num_w[l]) << 1) + N2W'(s3_absd_q);
      end
      s4_d2_q <= D2W'(s3_absd_q) << 1;
    end
  end

  // Stage 5 and divider stages. Index j holds the item after j quotient bits.
  info_t          dv_info_q [QW+1];
  logic [D2W-1:0] dv_d2_q   [QW+1];
  logic [RW-1:0]  dv_rem_q  [QW+1][3];
  logic [QW-1:0]  dv_quo_q  [QW+1][3];
  logic [2:0]     dv_ovf_q  [QW+1];

  // A quotient beyond QW bits lands far outside the coordinate range, so it only
  // needs to be flagged.
  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      dv_info_q[0] <= s4_info_q;
      dv_d2_q[0]   <= s4_d2_q;
      for (int l = 0; l < 3; l++) begin
        dv_rem_q[0][l] <= RW'(s4_n2_q[l]);
        dv_quo_q[0][l] <= '0;
        dv_ovf_q[0][l] <= RW'(s4_n2_q[l]) >= (RW'(s4_d2_q) << QW);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [RW-1:0] dsh;
    assign dsh = RW'(dv_d2_q[j]) << B;

    always_ff @(posedge clk_i) begin
      if (adv[5+j]) begin
        dv_info_q[j+1] <= dv_info_q[j];
        dv_d2_q[j+1]   <= dv_d2_q[j];
        dv_ovf_q[j+1]  <= dv_ovf_q[j];
        for (int l = 0; l < 3; l++) begin
          if (dv_rem_q[j][l] >= dsh) begin
            dv_rem_q[j+1][l] <= dv_rem_q[j][l] - dsh;
            dv_quo_q[j+1][l] <= dv_quo_q[j][l] | (QW'(1) << B);
          end else begin
            dv_rem_q[j+1][l] <= dv_rem_q[j][l];
            dv_quo_q[j+1][l] <= dv_quo_q[j][l];
          end
        end
      end
    end
  end

  // Final stage: intersection point, bounding box, saturation and side code.
  info_t                fi;
  logic signed [PTW-1:0] qv   [3];
  logic signed [PTW-1:0] pt   [3];
  logic signed [PTW-1:0] sv   [3];
  logic signed [PTW-1:0] ev   [3];
  logic signed [CW-1:0]  sat  [3];
  logic [2:0]            in_box;
  side_code_t            base_code;
  side_code_t            code_w;

  assign fi = dv_info_q[QW];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qv[l] = $signed(PTW'(dv_quo_q[QW][l]));
      if (fi.qneg[l]) begin
        qv[l] = -qv[l];
      end
      sv[l] = PTW'($signed(fi.s[l]));
      ev[l] = PTW'($signed(fi.e[l]));
      pt[l] = sv[l] + qv[l];
      in_box[l] = !dv_ovf_q[QW][l] &&
                  ((pt[l] >= sv[l] && pt[l] <= ev[l]) ||
                   (pt[l] >= ev[l] && pt[l] <= sv[l]));
      if (dv_ovf_q[QW][l]) begin
        sat[l] = fi.qneg[l] ? CW'(CMIN) : CW'(CMAX);
      end else if (pt[l] > CMAX) begin
        sat[l] = CW'(CMAX);
      end else if (pt[l] < CMIN) begin
        sat[l] = CW'(CMIN);
      end else begin
        sat[l] = CW'(pt[l]);
      end
    end

    if (fi.u_pos) begin
      base_code = SIDE_POS;
    end else if (fi.u_neg) begin
      base_code = SIDE_NEG;
    end else begin
      base_code = SIDE_IN_PLANE;
    end

    if (fi.par || !(&in_box)) begin
      code_w = base_code;
    end else if (fi.u_pos) begin
      code_w = fi.e_zero ? SIDE_POS : SIDE_CROSS_POS;
    end else if (fi.u_neg) begin
      code_w = fi.e_zero ? SIDE_NEG : SIDE_CROSS_NEG;
    end else begin
      // Start on the plane: the end point's side decides.
      code_w = fi.e_pos ? SIDE_POS : SIDE_NEG;
    end
  end

  side_code_t           out_code_q;
  logic                 out_pv_q;
  logic signed [CW-1:0] out_pt_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      out_code_q <= code_w;
      out_pv_q   <= !fi.par;
      for (int l = 0; l < 3; l++) begin
        out_pt_q[l] <= fi.par ? '0 : sat[l];
      end
    end
  end

  assign res_o.valid       = vld_q[NS-1];
  assign res_o.side_code   = out_code_q;
  assign res_o.point_valid = out_pv_q;
  assign res_o.cross_x     = out_pt_q[0];
  assign res_o.cross_y     = out_pt_q[1];
  assign res_o.cross_z     = out_pt_q[2];

endmodule
`default_nettype wire
